@@ design/dqkr_pkg.sv @@
// Shared constants, types and helpers for the deque with key removal.
// No dependencies.
package dqkr_pkg;

  localparam int DEPTH = 16;
  localparam int DW    = 32;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  typedef logic signed [DW-1:0] data_t;
  typedef logic [AW-1:0]        addr_t;
  typedef logic [CW-1:0]        cnt_t;
  typedef logic [2:0]           mode_t;
  typedef logic [1:0]           status_t;

  localparam mode_t MODE_PUSH_FRONT = 3'd0;
  localparam mode_t MODE_POP_FRONT  = 3'd1;
  localparam mode_t MODE_PUSH_BACK  = 3'd2;
  localparam mode_t MODE_POP_BACK   = 3'd3;
  localparam mode_t MODE_REMOVE_KEY = 3'd4;

  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  typedef struct packed {
    status_t status;
    cnt_t    count;
    data_t   front_value;
    data_t   back_value;
    cnt_t    removed;
  } res_t;

  // circular index: base + offset, offset below DEPTH
  function automatic addr_t wrap_add(addr_t base, cnt_t off);
    logic [AW:0] s;
    s = (AW+1)'(base) + (AW+1)'(off);
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return AW'(s);
  endfunction

endpackage

@@ design/dqkr_if.sv @@
// Valid/ready channel interfaces for requests and results.
// Depends on dqkr_pkg.
interface dqkr_req_if import dqkr_pkg::*; ();
  logic  valid;
  logic  ready;
  mode_t mode;
  data_t value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface dqkr_rsp_if import dqkr_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t status;
  cnt_t    count;
  data_t   front_value;
  data_t   back_value;
  cnt_t    removed;

  modport source (output valid, output status, output count, output front_value,
                  output back_value, output removed, input ready);
  modport sink   (input valid, input status, input count, input front_value,
                  input back_value, input removed, output ready);
endinterface

@@ design/deque_with_key_removal.sv @@
// Bounded deque of signed 32-bit values with delete-by-value. Entries sit in a
// circular buffer RAM addressed by a head pointer and a count, so a push or pop
// moves a pointer; the front and back values are kept in registers and refreshed
// by one RAM read after a pop. A push, an empty or full case, or an unused mode
// goes from idle straight to the done state; a pop that leaves entries passes
// the fetch state first, and a key removal the scan state, which streams every
// held entry through the one RAM read port and compare, writing kept entries
// back in order. One request is in work at a time; ready is high only while idle.
// Depends on dqkr_pkg, dqkr_if, dqkr_seq.
module deque_with_key_removal import dqkr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  dqkr_req_if.sink  req,
  dqkr_rsp_if.source rsp
);

  logic res_valid;
  logic res_ready;
  res_t res;

  dqkr_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
    if (res_valid && res_ready) begin
      rsp.status      <= res.status;
      rsp.count       <= res.count;
      rsp.front_value <= res.front_value;
      rsp.back_value  <= res.back_value;
      rsp.removed     <= res.removed;
    end
  end

endmodule

@@ design/dqkr_ram.sv @@
// Generic one-write one-read RAM with registered read data.
// No dependencies.
module dqkr_ram #(
  parameter int W = 32,
  parameter int D = 16,
  parameter int A = (D > 1) ? $clog2(D) : 1
) (
  input  logic         clk,
  input  logic         we,
  input  logic [A-1:0] waddr,
  input  logic [W-1:0] wdata,
  input  logic [A-1:0] raddr,
  output logic [W-1:0] rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/dqkr_seq.sv @@
// Sequencer: circular-buffer pointers, end values and the key-removal scan.
// Depends on dqkr_pkg, dqkr_if and dqkr_ram.
module dqkr_seq import dqkr_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  dqkr_req_if.sink       req,
  output logic           res_valid,
  input  logic           res_ready,
  output res_t           res
);

  typedef enum logic [1:0] {S_IDLE, S_FETCH, S_SCAN, S_DONE} state_t;

  state_t  state, state_next;
  addr_t   head, head_next;
  cnt_t    cnt, cnt_next;
  data_t   front, front_next;
  data_t   back, back_next;
  data_t   key, key_next;
  cnt_t    rd, rd_next;
  cnt_t    wr, wr_next;
  logic    pend, pend_next;
  logic    fetch_front, fetch_front_next;
  status_t status, status_next;
  cnt_t    removed, removed_next;

  logic  we;
  addr_t waddr, raddr;
  data_t wdata, rdata;
  addr_t head_dec;

  dqkr_ram #(.W(DW), .D(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign head_dec  = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);
  assign req.ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res       = '{status: status, count: cnt, front_value: front,
                       back_value: back, removed: removed};

  always_comb begin
    state_next       = state;
    head_next        = head;
    cnt_next         = cnt;
    front_next       = front;
    back_next        = back;
    key_next         = key;
    rd_next          = rd;
    wr_next          = wr;
    pend_next        = pend;
    fetch_front_next = fetch_front;
    status_next      = status;
    removed_next     = removed;
    we               = 1'b0;
    waddr            = head;
    wdata            = req.value;
    raddr            = head;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          status_next  = ST_DONE;
          removed_next = '0;
          state_next   = S_DONE;
          unique case (req.mode)
            MODE_PUSH_FRONT: begin
              if (cnt == CW'(DEPTH)) begin
                status_next = ST_FULL;
              end else begin
                we         = 1'b1;
                waddr      = head_dec;
                head_next  = head_dec;
                cnt_next   = cnt + CW'(1);
                front_next = req.value;
                if (cnt == '0) back_next = req.value;
              end
            end
            MODE_PUSH_BACK: begin
              if (cnt == CW'(DEPTH)) begin
                status_next = ST_FULL;
              end else begin
                we        = 1'b1;
                waddr     = wrap_add(head, cnt);
                cnt_next  = cnt + CW'(1);
                back_next = req.value;
                if (cnt == '0) front_next = req.value;
              end
            end
            MODE_POP_FRONT: begin
              if (cnt == '0) begin
                status_next = ST_EMPTY;
              end else begin
                cnt_next  = cnt - CW'(1);
                head_next = wrap_add(head, CW'(1));
                if (cnt == CW'(1)) begin
                  front_next = '0;
                  back_next  = '0;
                end else begin
                  raddr            = wrap_add(head, CW'(1));
                  fetch_front_next = 1'b1;
                  state_next       = S_FETCH;
                end
              end
            end
            MODE_POP_BACK: begin
              if (cnt == '0) begin
                status_next = ST_EMPTY;
              end else begin
                cnt_next = cnt - CW'(1);
                if (cnt == CW'(1)) begin
                  front_next = '0;
                  back_next  = '0;
                end else begin
                  raddr            = wrap_add(head, cnt - CW'(2));
                  fetch_front_next = 1'b0;
                  state_next       = S_FETCH;
                end
              end
            end
            MODE_REMOVE_KEY: begin
              if (cnt == '0) begin
                status_next = ST_EMPTY;
              end else begin
                key_next   = req.value;
                rd_next    = '0;
                wr_next    = '0;
                pend_next  = 1'b0;
                state_next = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_FETCH: begin
        if (fetch_front) begin
          front_next = rdata;
        end else begin
          back_next = rdata;
        end
        state_next = S_DONE;
      end
      S_SCAN: begin
        // read stage
        if (rd < cnt) begin
          raddr     = wrap_add(head, rd);
          rd_next   = rd + CW'(1);
          pend_next = 1'b1;
        end else begin
          pend_next = 1'b0;
        end
        // compare and compact stage
        if (pend && (rdata != key)) begin
          we        = 1'b1;
          waddr     = wrap_add(head, wr);
          wdata     = rdata;
          wr_next   = wr + CW'(1);
          back_next = rdata;
          if (wr == '0) front_next = rdata;
        end
        if (!pend && (rd == cnt)) begin
          cnt_next     = wr;
          removed_next = cnt - wr;
          if (wr == '0) begin
            front_next = '0;
            back_next  = '0;
          end
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      cnt   <= '0;
      front <= '0;
      back  <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      cnt   <= cnt_next;
      front <= front_next;
      back  <= back_next;
      pend  <= pend_next;
    end
    key         <= key_next;
    rd          <= rd_next;
    wr          <= wr_next;
    fetch_front <= fetch_front_next;
    status      <= status_next;
    removed     <= removed_next;
  end

endmodule
